FILE: sv/sshp_pkg.sv
// Shared types and constants for the staged-setpoint PID heater.
// No dependencies.
package sshp_pkg;

	typedef enum logic [1:0] {
		ACT_PERIOD  = 2'd0,
		ACT_STAGE   = 2'd1,
		ACT_COMPUTE = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		K_PERIOD,
		K_STAGE,
		K_COMPUTE,
		K_NONE
	} kind_t;

	typedef enum logic [2:0] {
		REG_SETPOINT = 3'd0,
		REG_GAIN     = 3'd1,
		REG_PERIOD   = 3'd2,
		REG_ITIME    = 3'd3,
		REG_DTIME    = 3'd4,
		REG_DMAX     = 3'd5,
		REG_DFLOOR   = 3'd6,
		REG_STAGING  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] setpoint;
		logic [15:0] gain;
		logic [15:0] period;
		logic [15:0] itime;
		logic [15:0] dtime;
		logic [15:0] dmax;
		logic [15:0] dfloor;
		logic        staging;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] meas;
	} item_t;

	typedef struct packed {
		logic busy;
	} back_st_t;

	typedef enum logic [1:0] {
		MU_IDLE,
		MU_MUL,
		MU_DIV,
		MU_DONE
	} mu_state_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_TGT,
		BK_TGT_W,
		BK_P,
		BK_I,
		BK_I_W,
		BK_D,
		BK_D_W,
		BK_FIN
	} bk_state_t;

	localparam logic [15:0] STAGE_T0 = 16'd60;
	localparam logic [15:0] STAGE_T1 = 16'd100;
	localparam logic [15:0] STAGE_T2 = 16'd200;
	localparam logic [15:0] STAGE_T3 = 16'd300;
	localparam logic [15:0] STAGE_T4 = 16'd400;
	localparam logic [6:0]  PCT_60   = 7'd60;
	localparam logic [6:0]  PCT_80   = 7'd80;
	localparam logic [6:0]  PCT_85   = 7'd85;
	localparam logic [6:0]  PCT_90   = 7'd90;
	localparam logic [6:0]  PCT_95   = 7'd95;
	localparam logic [6:0]  PCT_100  = 7'd100;
	localparam logic [6:0]  COLD_PCT = 7'd55;
	localparam logic [15:0] CNT_MAX  = 16'hFFFF;
	localparam logic [60:0] TERM_MAX = 61'h1000_0000_0000_0000;

endpackage

FILE: sv/staged_setpoint_pid_heater.sv
// Top level of the staged-setpoint PID heater: configuration registers,
// front queue and back sequencer. Depends on sshp_pkg, sshp_front, sshp_back.
//
// Tick and ignored beats pass through the front queue; when the back end is idle and no
// result waits, it pops them and registers m_tvalid. A compute beat whose period has
// elapsed runs target scaling and the P term, then two passes of the shared serial
// mul-div unit (I, D), each 32 multiply steps, 96 divide steps and a done state, then
// a final clamp state that registers m_tvalid. A two-beat queue keeps input accepted,
// until it is full, while the back end works or a result waits.
module staged_setpoint_pid_heater #(
	parameter int VALUE_WIDTH = 16,
	parameter int SUM_WIDTH   = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] measured
	input  logic [1:0]  s_tuser,   // [1:0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] drive
	output logic [0:0]  m_tuser,   // [0] updated
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	sshp_pkg::cfg_t     cfg_q;
	logic               q_valid, q_pop, upd;
	sshp_pkg::item_t    q_item;
	sshp_pkg::back_st_t bst;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint <= 16'd0;
			cfg_q.gain     <= 16'd256;
			cfg_q.period   <= 16'd100;
			cfg_q.itime    <= 16'd65535;
			cfg_q.dtime    <= 16'd0;
			cfg_q.dmax     <= 16'd1000;
			cfg_q.dfloor   <= 16'd0;
			cfg_q.staging  <= 1'b0;
		end else if (cfg_valid) begin
			unique case (sshp_pkg::reg_idx_t'(cfg_index))
				sshp_pkg::REG_SETPOINT: cfg_q.setpoint <= cfg_data;
				sshp_pkg::REG_GAIN:     cfg_q.gain     <= cfg_data;
				sshp_pkg::REG_PERIOD:   cfg_q.period   <= cfg_data;
				sshp_pkg::REG_ITIME:    cfg_q.itime    <= cfg_data;
				sshp_pkg::REG_DTIME:    cfg_q.dtime    <= cfg_data;
				sshp_pkg::REG_DMAX:     cfg_q.dmax     <= cfg_data;
				sshp_pkg::REG_DFLOOR:   cfg_q.dfloor   <= cfg_data;
				sshp_pkg::REG_STAGING:  cfg_q.staging  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	sshp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_meas   (s_tdata),
		.in_action (s_tuser),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	sshp_back #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.SUM_WIDTH   (SUM_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_drive (m_tdata),
		.out_upd   (upd),
		.st        (bst)
	);

	assign m_tuser = upd;

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata <= cfg_q.dmax) || (m_tdata == cfg_q.dfloor))
		else $error("updated drive outside clamp");

	a_idle_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !bst.busy)
		else $error("back end busy while a result waits");

	a_upd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

endmodule

FILE: sv/sshp_front.sv
// Front end: accepts input beats, classifies them and queues them (two entries).
// Depends on sshp_pkg.
module sshp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [15:0]         in_meas,
	input  logic [1:0]          in_action,
	output logic                q_valid,
	output sshp_pkg::item_t     q_item,
	input  logic                q_pop
);

	sshp_pkg::item_t ent_q [2];
	logic            wr_ptr_q, rd_ptr_q;
	logic [1:0]      count_q;
	sshp_pkg::kind_t kind;
	logic            push;

	always_comb begin
		unique case (sshp_pkg::action_t'(in_action))
			sshp_pkg::ACT_PERIOD:  kind = sshp_pkg::K_PERIOD;
			sshp_pkg::ACT_STAGE:   kind = sshp_pkg::K_STAGE;
			sshp_pkg::ACT_COMPUTE: kind = sshp_pkg::K_COMPUTE;
			default:               kind = sshp_pkg::K_NONE;
		endcase
	end

	assign in_ready = (count_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= '{kind: kind, meas: in_meas};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

FILE: sv/sshp_muldiv.sv
// Shared serial unit: trunc(a*b/c) saturated to 2^60; shift-add multiply over
// the 32 multiplier bits then restoring division over 96 bits. Depends on sshp_pkg.
module sshp_muldiv (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [31:0] b,
	input  logic [31:0] c,
	output logic        done,
	output logic [60:0] q
);

	sshp_pkg::mu_state_t state_q, state_n;
	logic [6:0]  cnt_q;
	logic [95:0] acc_q;
	logic [95:0] ash_q;
	logic [31:0] b_q;
	logic [31:0] c_q;
	logic [31:0] rem_q;
	logic [32:0] rem_n;
	logic        ge;
	logic        sat;

	assign rem_n = {rem_q, acc_q[95]};
	assign ge    = rem_n >= {1'b0, c_q};

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			sshp_pkg::MU_IDLE: if (start) state_n = sshp_pkg::MU_MUL;
			sshp_pkg::MU_MUL:  if (cnt_q == 7'd31) state_n = sshp_pkg::MU_DIV;
			sshp_pkg::MU_DIV:  if (cnt_q == 7'd95) state_n = sshp_pkg::MU_DONE;
			sshp_pkg::MU_DONE: state_n = sshp_pkg::MU_IDLE;
			default:           state_n = sshp_pkg::MU_IDLE;
		endcase
	end

	always_comb begin
		sat  = (acc_q[95:61] != '0) || (acc_q[60] && (acc_q[59:0] != '0));
		done = (state_q == sshp_pkg::MU_DONE);
		q    = sat ? sshp_pkg::TERM_MAX : acc_q[60:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sshp_pkg::MU_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			if (state_q != state_n) cnt_q <= '0;
			else cnt_q <= cnt_q + 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			sshp_pkg::MU_IDLE: begin
				if (start) begin
					acc_q <= '0;
					ash_q <= {32'd0, a};
					b_q   <= b;
					c_q   <= c;
					rem_q <= '0;
				end
			end
			sshp_pkg::MU_MUL: begin
				if (b_q[0]) acc_q <= acc_q + ash_q;
				ash_q <= {ash_q[94:0], 1'b0};
				b_q   <= {1'b0, b_q[31:1]};
			end
			sshp_pkg::MU_DIV: begin
				rem_q <= ge ? 32'(rem_n - {1'b0, c_q}) : rem_n[31:0];
				acc_q <= {acc_q[94:0], ge};
			end
			default: ;
		endcase
	end

endmodule

FILE: sv/sshp_back.sv
// Back end: tick counters, PID sequencer over the shared mul-div unit and
// the result register. Depends on sshp_pkg and sshp_muldiv.
module sshp_back #(
	parameter int VALUE_WIDTH = 16,
	parameter int SUM_WIDTH   = 48
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sshp_pkg::cfg_t      cfg,
	input  logic                q_valid,
	input  sshp_pkg::item_t     q_item,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [15:0]         out_drive,
	output logic                out_upd,
	output sshp_pkg::back_st_t  st
);

	localparam int VW     = VALUE_WIDTH;
	localparam int PW     = VALUE_WIDTH + 7;
	localparam int TGT_SH = VALUE_WIDTH + 14;
	localparam int RW     = TGT_SH - 6;
	// reciprocal of 100, exact floor for every setpoint * percentage
	localparam logic [RW-1:0] RECIP_100 = RW'(((64'd1 << TGT_SH) +
		64'(sshp_pkg::PCT_100) - 64'd1) / 64'(sshp_pkg::PCT_100));

	sshp_pkg::bk_state_t state_q, state_n;

	logic [15:0]                 period_q, stage_q, held_q;
	logic signed [SUM_WIDTH-1:0] sum_q;
	logic signed [VW:0]          last_q, e_q;
	logic signed [VW+1:0]        de_q;
	logic [VW-1:0]               meas_q;
	logic signed [63:0]          total_q;
	logic                        out_valid_q, out_upd_q;
	logic [15:0]                 out_drive_q;
	logic [PW-1:0]               scaled_q;
	logic [VW-1:0]               tgt_q;

	logic [15:0]  per, ti;
	logic [VW-1:0] sp, meas_in;
	logic         run, cold;
	logic [6:0]   pct;
	logic         mu_start, mu_done;
	logic [63:0]  mu_a;
	logic [31:0]  mu_b, mu_c;
	logic [60:0]  mu_q;
	logic signed [VW:0]   e_n;
	logic signed [65:0]   sum_w, smax, smin;
	logic signed [64:0]   e65, s65, d65;
	logic [63:0]          e_mag, s_mag, d_mag;
	logic signed [63:0]   term;
	logic                 neg;
	logic signed [55:0]   dsh;
	logic [PW+RW-1:0]     tgt_w;
	logic [VW+16:0]       p_mag;
	logic signed [63:0]   p_term;

	assign per     = (cfg.period == '0) ? 16'd1 : cfg.period;
	assign ti      = (cfg.itime == '0) ? 16'd1 : cfg.itime;
	assign sp      = VW'(cfg.setpoint);
	assign meas_in = VW'(q_item.meas);
	assign run     = (q_item.kind == sshp_pkg::K_COMPUTE) && (period_q >= per);
	assign cold    = (PW'(meas_in) * PW'(7'd100)) < (PW'(sp) * PW'(sshp_pkg::COLD_PCT));
	assign q_pop   = (state_q == sshp_pkg::BK_IDLE) && q_valid && !out_valid_q;

	always_comb begin
		priority if (!cfg.staging)                pct = sshp_pkg::PCT_100;
		else if (stage_q <= sshp_pkg::STAGE_T0)   pct = sshp_pkg::PCT_60;
		else if (stage_q <= sshp_pkg::STAGE_T1)   pct = sshp_pkg::PCT_80;
		else if (stage_q <= sshp_pkg::STAGE_T2)   pct = sshp_pkg::PCT_85;
		else if (stage_q <= sshp_pkg::STAGE_T3)   pct = sshp_pkg::PCT_90;
		else if (stage_q <= sshp_pkg::STAGE_T4)   pct = sshp_pkg::PCT_95;
		else                                      pct = sshp_pkg::PCT_100;
	end

	always_comb begin
		tgt_w  = (PW+RW)'(scaled_q) * (PW+RW)'(RECIP_100);
		e_n    = $signed({1'b0, tgt_q}) - $signed({1'b0, meas_q});
		sum_w  = 66'(sum_q) + 66'(e_n);
		smax   = (66'sd1 <<< (SUM_WIDTH - 1)) - 66'sd1;
		smin   = -smax - 66'sd1;
		e65    = 65'(e_q);
		s65    = 65'(sum_q);
		d65    = 65'(de_q);
		e_mag  = e65[64] ? 64'(-e65) : e65[63:0];
		s_mag  = s65[64] ? 64'(-s65) : s65[63:0];
		d_mag  = d65[64] ? 64'(-d65) : d65[63:0];
		dsh    = 56'(total_q >>> 8);
		p_mag  = (VW+17)'(e_mag[VW:0]) * (VW+17)'(cfg.gain);
		p_term = e_q[VW] ? -$signed(64'(p_mag)) : $signed(64'(p_mag));
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			sshp_pkg::BK_IDLE:  if (q_pop && run) state_n = sshp_pkg::BK_TGT;
			sshp_pkg::BK_TGT:   state_n = sshp_pkg::BK_TGT_W;
			sshp_pkg::BK_TGT_W: state_n = sshp_pkg::BK_P;
			sshp_pkg::BK_P:     state_n = sshp_pkg::BK_I;
			sshp_pkg::BK_I:     state_n = sshp_pkg::BK_I_W;
			sshp_pkg::BK_I_W:   if (mu_done) state_n = sshp_pkg::BK_D;
			sshp_pkg::BK_D:     state_n = sshp_pkg::BK_D_W;
			sshp_pkg::BK_D_W:   if (mu_done) state_n = sshp_pkg::BK_FIN;
			sshp_pkg::BK_FIN:   state_n = sshp_pkg::BK_IDLE;
			default:            state_n = sshp_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		mu_start = 1'b0;
		mu_a     = s_mag;
		mu_b     = 32'(cfg.gain) * 32'(per);
		mu_c     = 32'(ti);
		neg      = 1'b0;
		unique case (state_q)
			sshp_pkg::BK_I: mu_start = 1'b1;
			sshp_pkg::BK_D: begin
				mu_start = 1'b1;
				mu_a     = d_mag;
				mu_b     = 32'(cfg.gain) * 32'(cfg.dtime);
				mu_c     = 32'(per);
			end
			sshp_pkg::BK_I_W: neg = sum_q[SUM_WIDTH-1];
			sshp_pkg::BK_D_W: neg = de_q[VW+1];
			default: ;
		endcase
		term = neg ? -$signed(64'(mu_q)) : $signed(64'(mu_q));
	end

	sshp_muldiv u_mu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mu_start),
		.a      (mu_a),
		.b      (mu_b),
		.c      (mu_c),
		.done   (mu_done),
		.q      (mu_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sshp_pkg::BK_IDLE;
			period_q    <= '0;
			stage_q     <= '0;
			held_q      <= '0;
			sum_q       <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
			out_upd_q   <= 1'b0;
			out_drive_q <= '0;
		end else begin
			state_q <= state_n;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				sshp_pkg::BK_IDLE: begin
					if (q_pop) begin
						if (run) begin
							if (cfg.staging && cold) stage_q <= '0;
						end else begin
							if (q_item.kind == sshp_pkg::K_PERIOD && period_q != sshp_pkg::CNT_MAX)
								period_q <= period_q + 16'd1;
							if (q_item.kind == sshp_pkg::K_STAGE && stage_q != sshp_pkg::CNT_MAX)
								stage_q <= stage_q + 16'd1;
							out_valid_q <= 1'b1;
							out_upd_q   <= 1'b0;
							out_drive_q <= held_q;
						end
					end
				end
				sshp_pkg::BK_P: begin
					if (sum_w > smax) sum_q <= SUM_WIDTH'(smax);
					else if (sum_w < smin) sum_q <= SUM_WIDTH'(smin);
					else sum_q <= SUM_WIDTH'(sum_w);
				end
				sshp_pkg::BK_FIN: begin
					if (total_q[63]) held_q <= cfg.dfloor;
					else if (dsh > 56'(cfg.dmax)) held_q <= cfg.dmax;
					else held_q <= dsh[15:0];
					if (total_q[63]) out_drive_q <= cfg.dfloor;
					else if (dsh > 56'(cfg.dmax)) out_drive_q <= cfg.dmax;
					else out_drive_q <= dsh[15:0];
					last_q      <= e_q;
					period_q    <= '0;
					out_valid_q <= 1'b1;
					out_upd_q   <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) meas_q <= meas_in;
		if (state_q == sshp_pkg::BK_TGT) scaled_q <= PW'(sp) * PW'(pct);
		if (state_q == sshp_pkg::BK_TGT_W) tgt_q <= tgt_w[TGT_SH +: VW];
		if (state_q == sshp_pkg::BK_P) begin
			e_q  <= e_n;
			de_q <= (VW+2)'(e_n) - (VW+2)'(last_q);
		end
		if (state_q == sshp_pkg::BK_I) total_q <= p_term;
		if ((state_q == sshp_pkg::BK_I_W || state_q == sshp_pkg::BK_D_W) && mu_done)
			total_q <= total_q + term;
	end

	assign out_valid = out_valid_q;
	assign out_drive = out_drive_q;
	assign out_upd   = out_upd_q;
	assign st.busy   = (state_q != sshp_pkg::BK_IDLE);

endmodule
